FILE: hdl/wrhf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrhf_pkg
// Types, constants and pattern tables for the water ripple height field unit.
// ----------------------------------------------------------------------------
package wrhf_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int HEIGHT_W   = 16;
  localparam int PIXEL_W    = 32;
  localparam int INDEX_W    = 12;
  localparam int COORD_W    = 6;
  localparam int ACC_W      = 18;
  localparam int PHASE_W    = 4;

  localparam logic [7:0] DROP_CENTER = 8'd254;
  localparam logic [7:0] DROP_SIDE_X = 8'd193;
  localparam logic [7:0] DROP_SIDE_Y = 8'd183;
  localparam logic [7:0] DROP_CORNER = 8'd172;
  localparam int DAMP_SHIFT = 7;
  localparam int DISP_SHIFT = 4;

  // Sequencer phases that end or mark a pass.
  localparam logic [PHASE_W-1:0] DROP_LAST_PH = 4'd8;
  localparam logic [PHASE_W-1:0] NBR_FIRST_PH = 4'd1;
  localparam logic [PHASE_W-1:0] NBR_LAST_PH  = 4'd8;
  localparam logic [PHASE_W-1:0] STEP_WB_PH   = 4'd9;
  localparam logic [PHASE_W-1:0] RD_ADDR0_PH  = 4'd0;
  localparam logic [PHASE_W-1:0] RD_ADDR1_PH  = 4'd1;
  localparam logic [PHASE_W-1:0] RD_ADDR2_PH  = 4'd2;
  localparam logic [PHASE_W-1:0] RD_SUM_PH    = 4'd3;
  localparam logic [PHASE_W-1:0] RD_TGT_PH    = 4'd4;
  localparam logic [PHASE_W-1:0] RD_LAST_PH   = 4'd5;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_DROP = 2'd1,
    MODE_STEP = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DROP,
    S_STEP,
    S_RDH,
    S_RDOUT
  } state_t;

  // One cell of a 3x3 pattern: column and row offset in {-1, 0, +1}.
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic [7:0]        val;
  } cell_step_t;

  function automatic cell_step_t drop_step(input logic [PHASE_W-1:0] ph);
    cell_step_t r;
    case (ph)
      4'd0:    r = '{dx: 2'sd0,  dy: 2'sd0,  val: DROP_CENTER};
      4'd1:    r = '{dx: 2'sd1,  dy: 2'sd0,  val: DROP_SIDE_X};
      4'd2:    r = '{dx: -2'sd1, dy: 2'sd0,  val: DROP_SIDE_X};
      4'd3:    r = '{dx: 2'sd0,  dy: 2'sd1,  val: DROP_SIDE_Y};
      4'd4:    r = '{dx: 2'sd0,  dy: -2'sd1, val: DROP_SIDE_Y};
      4'd5:    r = '{dx: 2'sd1,  dy: 2'sd1,  val: DROP_CORNER};
      4'd6:    r = '{dx: -2'sd1, dy: -2'sd1, val: DROP_CORNER};
      4'd7:    r = '{dx: -2'sd1, dy: 2'sd1,  val: DROP_CORNER};
      4'd8:    r = '{dx: 2'sd1,  dy: -2'sd1, val: DROP_CORNER};
      default: r = '{dx: 2'sd0,  dy: 2'sd0,  val: DROP_CENTER};
    endcase
    return r;
  endfunction

  // The eight neighbors of a cell, visited in raster order.
  function automatic cell_step_t nbr_step(input logic [PHASE_W-1:0] ph);
    cell_step_t r;
    case (ph)
      4'd0:    r = '{dx: -2'sd1, dy: -2'sd1, val: 8'd0};
      4'd1:    r = '{dx: 2'sd0,  dy: -2'sd1, val: 8'd0};
      4'd2:    r = '{dx: 2'sd1,  dy: -2'sd1, val: 8'd0};
      4'd3:    r = '{dx: -2'sd1, dy: 2'sd0,  val: 8'd0};
      4'd4:    r = '{dx: 2'sd1,  dy: 2'sd0,  val: 8'd0};
      4'd5:    r = '{dx: -2'sd1, dy: 2'sd1,  val: 8'd0};
      4'd6:    r = '{dx: 2'sd0,  dy: 2'sd1,  val: 8'd0};
      4'd7:    r = '{dx: 2'sd1,  dy: 2'sd1,  val: 8'd0};
      default: r = '{dx: 2'sd0,  dy: 2'sd0,  val: 8'd0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/water_ripple_height_field_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// water_ripple_height_field_unit
// Two-buffer water ripple height field with a background image and a
// displaced pixel read, run by a small sequencer over memories with one read and one write port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_*      input      in_tvalid/in_tready  in_tuser = mode, in_tdata = operands
//  out_*     output     out_tvalid/out_tready out_tdata = displaced pixel
//
//  After reset both height buffers are zeroed, one cell a cycle; no request
//  is accepted meanwhile. A background load is written as it is accepted;
//  a drop makes nine writes. A grid step visits each interior cell in turn,
//  reading its eight neighbors one at a time through the one read port of
//  the current height buffer. A pixel read sums three heights, then fetches
//  the displaced background pixel; the result waits in an output register
//  and the next request is still taken, but a second read then holds in its
//  last state until the first result has been taken.
// ----------------------------------------------------------------------------
module water_ripple_height_field_unit #(
  parameter int GRID_WIDTH  = wrhf_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wrhf_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [11:0] cell_index, [43:12] bg_value, [49:44] drop_x, [55:50] drop_y
  input  wire logic [wrhf_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  wire logic [wrhf_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [31:0] pixel
  output logic [wrhf_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int IW    = $clog2(CELLS);
  localparam int KW    = ((IW > wrhf_pkg::INDEX_W) ? IW : wrhf_pkg::INDEX_W) + 1;
  localparam int TW    = ((KW > 14) ? KW : 14) + 1;
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int HW    = wrhf_pkg::HEIGHT_W;
  localparam int PW    = wrhf_pkg::PHASE_W;

  localparam logic [IW-1:0] W_IW       = IW'(GRID_WIDTH);
  localparam logic [IW-1:0] LAST_CELL  = IW'(CELLS - 1);
  localparam logic [IW-1:0] STEP_FIRST = IW'(GRID_WIDTH + 1);
  localparam logic [IW-1:0] STEP_LAST  = IW'((GRID_HEIGHT - 2) * GRID_WIDTH + GRID_WIDTH - 2);
  localparam logic [XW-1:0] X_LAST     = XW'(GRID_WIDTH - 2);
  localparam logic [KW-1:0] CELLS_K    = KW'(CELLS);
  localparam logic [TW-1:0] LAST_T     = TW'(CELLS - 1);
  localparam logic [10:0]   X_HI       = 11'(GRID_WIDTH - 2);
  localparam logic [10:0]   Y_HI       = 11'(GRID_HEIGHT - 2);

  // Input fields.
  logic [wrhf_pkg::INDEX_W-1:0] in_cell_index;
  logic [wrhf_pkg::PIXEL_W-1:0] in_bg_value;
  logic [wrhf_pkg::COORD_W-1:0] in_drop_x;
  logic [wrhf_pkg::COORD_W-1:0] in_drop_y;
  wrhf_pkg::mode_t              in_mode;

  assign in_cell_index = in_tdata[11:0];
  assign in_bg_value   = in_tdata[43:12];
  assign in_drop_x     = in_tdata[49:44];
  assign in_drop_y     = in_tdata[55:50];
  assign in_mode       = wrhf_pkg::mode_t'(in_tuser);

  // Registers.
  wrhf_pkg::state_t          state_r, state_nxt;
  logic [PW-1:0]             phase_r, phase_nxt;
  logic [IW-1:0]             c_r, c_nxt;
  logic [XW-1:0]             x_r, x_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic [wrhf_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                      zero_r, zero_nxt;
  logic [IW-1:0]             target_r, target_nxt;
  logic                      cur_sel_r, cur_sel_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [wrhf_pkg::PIXEL_W-1:0] out_data_r, out_data_nxt;

  // Memory controls, seen from the current and the other height buffer.
  logic [IW-1:0] cur_raddr, oth_raddr, cur_waddr, oth_waddr;
  logic          cur_we, oth_we;
  logic [HW-1:0] cur_wdata, oth_wdata, rd_cur, rd_oth;
  logic [IW-1:0] a_raddr, b_raddr, a_waddr, b_waddr;
  logic          a_we, b_we;
  logic [HW-1:0] a_wdata, b_wdata, a_rdata_r, b_rdata_r;
  logic          bg_we;
  logic [IW-1:0] bg_waddr;
  logic [wrhf_pkg::PIXEL_W-1:0] bg_rdata_r;

  logic [HW-1:0] height_a [CELLS];
  logic [HW-1:0] height_b [CELLS];
  logic [wrhf_pkg::PIXEL_W-1:0] background [CELLS];

  // Datapath helpers.
  wrhf_pkg::cell_step_t drop_s, nbr_s;
  logic [KW-1:0] in_k, kp1, kpw;
  logic          v1, v2, drop_ok;
  logic [IW-1:0] drop_c;
  logic [HW-1:0] s_val, t_val, step_val;
  logic [TW-1:0] tsum;

  function automatic logic [IW-1:0] cell_off(input logic signed [1:0] dx,
                                             input logic signed [1:0] dy);
    logic [IW-1:0] oy;
    logic [IW-1:0] ox;
    oy = (dy == 2'sd1) ? W_IW : ((dy == -2'sd1) ? (IW'(0) - W_IW) : IW'(0));
    ox = (dx == 2'sd1) ? IW'(1) : ((dx == -2'sd1) ? {IW{1'b1}} : IW'(0));
    return oy + ox;
  endfunction

  assign drop_s  = wrhf_pkg::drop_step(phase_r);
  assign nbr_s   = wrhf_pkg::nbr_step(phase_r);
  assign in_k    = KW'(in_cell_index);
  assign kp1     = k_r + KW'(1);
  assign kpw     = k_r + KW'(GRID_WIDTH);
  assign v1      = kp1 < CELLS_K;
  assign v2      = kpw < CELLS_K;
  assign drop_ok = (in_drop_x != '0) && (11'(in_drop_x) <= X_HI) &&
                   (in_drop_y != '0) && (11'(in_drop_y) <= Y_HI);
  assign drop_c  = IW'(32'(in_drop_y) * GRID_WIDTH + 32'(in_drop_x));

  // Damped wave update: neighbor sum over four against the damped old value.
  assign s_val    = {2'b00, acc_r[HW-1:2]};
  assign t_val    = rd_oth + (rd_oth >> wrhf_pkg::DAMP_SHIFT);
  assign step_val = (s_val > t_val) ? (s_val - t_val) : '0;

  assign tsum = TW'(k_r) + TW'(acc_r >> wrhf_pkg::DISP_SHIFT);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    c_nxt         = c_r;
    x_nxt         = x_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    zero_nxt      = zero_r;
    target_nxt    = target_r;
    cur_sel_nxt   = cur_sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    cur_raddr     = c_r;
    oth_raddr     = c_r;
    cur_we        = 1'b0;
    cur_waddr     = c_r;
    cur_wdata     = '0;
    oth_we        = 1'b0;
    oth_waddr     = c_r;
    oth_wdata     = '0;
    bg_we         = 1'b0;
    bg_waddr      = IW'(in_cell_index);

    unique case (state_r)
      wrhf_pkg::S_CLEAR: begin
        cur_we = 1'b1;
        oth_we = 1'b1;
        if (c_r == LAST_CELL) begin
          c_nxt     = '0;
          state_nxt = wrhf_pkg::S_IDLE;
        end else begin
          c_nxt = c_r + IW'(1);
        end
      end
      wrhf_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          phase_nxt = '0;
          unique case (in_mode)
            wrhf_pkg::MODE_LOAD: begin
              bg_we = in_k < CELLS_K;
            end
            wrhf_pkg::MODE_DROP: begin
              if (drop_ok) begin
                c_nxt     = drop_c;
                state_nxt = wrhf_pkg::S_DROP;
              end
            end
            wrhf_pkg::MODE_STEP: begin
              c_nxt     = STEP_FIRST;
              x_nxt     = XW'(1);
              state_nxt = wrhf_pkg::S_STEP;
            end
            wrhf_pkg::MODE_READ: begin
              k_nxt = in_k;
              if (in_k < CELLS_K) begin
                zero_nxt  = 1'b0;
                state_nxt = wrhf_pkg::S_RDH;
              end else begin
                zero_nxt  = 1'b1;
                state_nxt = wrhf_pkg::S_RDOUT;
              end
            end
            default: state_nxt = wrhf_pkg::S_IDLE;
          endcase
        end
      end
      wrhf_pkg::S_DROP: begin
        cur_we    = 1'b1;
        cur_waddr = c_r + cell_off(drop_s.dx, drop_s.dy);
        cur_wdata = HW'(drop_s.val);
        phase_nxt = phase_r + PW'(1);
        if (phase_r == wrhf_pkg::DROP_LAST_PH) begin
          state_nxt = wrhf_pkg::S_IDLE;
        end
      end
      wrhf_pkg::S_STEP: begin
        // Neighbor reads go out in phases 0..7 and land in the following phase.
        cur_raddr = c_r + cell_off(nbr_s.dx, nbr_s.dy);
        if (phase_r == wrhf_pkg::NBR_FIRST_PH) begin
          acc_nxt = {2'b00, rd_cur};
        end else if (phase_r > wrhf_pkg::NBR_FIRST_PH && phase_r <= wrhf_pkg::NBR_LAST_PH) begin
          acc_nxt = {2'b00, acc_r[HW-1:0] + rd_cur};
        end
        if (phase_r == wrhf_pkg::STEP_WB_PH) begin
          oth_we    = 1'b1;
          oth_wdata = step_val;
          phase_nxt = '0;
          if (c_r == STEP_LAST) begin
            cur_sel_nxt = !cur_sel_r;
            state_nxt   = wrhf_pkg::S_IDLE;
          end else if (x_r == X_LAST) begin
            c_nxt = c_r + IW'(3);
            x_nxt = XW'(1);
          end else begin
            c_nxt = c_r + IW'(1);
            x_nxt = x_r + XW'(1);
          end
        end else begin
          phase_nxt = phase_r + PW'(1);
        end
      end
      wrhf_pkg::S_RDH: begin
        phase_nxt = phase_r + PW'(1);
        case (phase_r)
          wrhf_pkg::RD_ADDR0_PH: cur_raddr = k_r[IW-1:0];
          wrhf_pkg::RD_ADDR1_PH: begin
            cur_raddr = kp1[IW-1:0];
            acc_nxt   = {2'b00, rd_cur};
          end
          wrhf_pkg::RD_ADDR2_PH: begin
            cur_raddr = kpw[IW-1:0];
            acc_nxt   = acc_r + (v1 ? wrhf_pkg::ACC_W'(rd_cur) : '0);
          end
          wrhf_pkg::RD_SUM_PH: begin
            acc_nxt = acc_r + (v2 ? wrhf_pkg::ACC_W'(rd_cur) : '0);
          end
          wrhf_pkg::RD_TGT_PH: begin
            target_nxt = (tsum > LAST_T) ? LAST_CELL : tsum[IW-1:0];
          end
          wrhf_pkg::RD_LAST_PH: state_nxt = wrhf_pkg::S_RDOUT;
          default: state_nxt = wrhf_pkg::S_RDOUT;
        endcase
      end
      wrhf_pkg::S_RDOUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = zero_r ? '0 : bg_rdata_r;
          state_nxt     = wrhf_pkg::S_IDLE;
        end
      end
      default: state_nxt = wrhf_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrhf_pkg::S_CLEAR;
      phase_r     <= '0;
      c_r         <= '0;
      cur_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      c_r         <= c_nxt;
      cur_sel_r   <= cur_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    zero_r     <= zero_nxt;
    target_r   <= target_nxt;
    out_data_r <= out_data_nxt;
  end

  // Route current/other requests onto buffer A and B.
  always_comb begin
    a_raddr = cur_sel_r ? oth_raddr : cur_raddr;
    b_raddr = cur_sel_r ? cur_raddr : oth_raddr;
    a_we    = cur_sel_r ? oth_we    : cur_we;
    b_we    = cur_sel_r ? cur_we    : oth_we;
    a_waddr = cur_sel_r ? oth_waddr : cur_waddr;
    b_waddr = cur_sel_r ? cur_waddr : oth_waddr;
    a_wdata = cur_sel_r ? oth_wdata : cur_wdata;
    b_wdata = cur_sel_r ? cur_wdata : oth_wdata;
    rd_cur  = cur_sel_r ? b_rdata_r : a_rdata_r;
    rd_oth  = cur_sel_r ? a_rdata_r : b_rdata_r;
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      height_a[a_waddr] <= a_wdata;
    end
    a_rdata_r <= height_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      height_b[b_waddr] <= b_wdata;
    end
    b_rdata_r <= height_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      background[bg_waddr] <= in_bg_value;
    end
    bg_rdata_r <= background[target_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The last cell of a step flips the current buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wrhf_pkg::S_STEP && phase_r == wrhf_pkg::STEP_WB_PH && c_r == STEP_LAST)
    |=> (cur_sel_r != $past(cur_sel_r)))
    else $error("current buffer did not flip at the end of a step");

  // A step only ever visits interior cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wrhf_pkg::S_STEP) |-> (c_r >= STEP_FIRST && c_r <= STEP_LAST))
    else $error("step cell index left the interior");

  // Outside the clearing pass the two buffers are never written together.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != wrhf_pkg::S_CLEAR) |-> !(cur_we && oth_we))
    else $error("both height buffers written outside the clearing pass");

  // A result only appears after the read sequence has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == wrhf_pkg::S_RDOUT))
    else $error("result raised outside a pixel read");

  // The current buffer only changes while a step is finishing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cur_sel_r != $past(cur_sel_r)) |-> ($past(state_r) == wrhf_pkg::S_STEP))
    else $error("current buffer changed outside a step");

endmodule
`default_nettype wire
